[hw/rtl/bracket_balance_lexer_top_assert.svh]
// Assertion macros for the bracket balance lexer.
`ifndef BRACKET_BALANCE_LEXER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_LEXER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BBL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket balance lexer: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BBL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket balance lexer: next-cycle check failed");

`endif

[hw/rtl/bbl_pkg.sv]
// Types and constants shared by the bracket balance lexer modules.
package bbl_pkg;

    localparam int DEPTH_BITS = 16;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX  = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN  = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ZERO = '0;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;

    typedef enum logic [2:0] {
        MODE_CODE   = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_SQUOTE = 3'd3,
        MODE_DQUOTE = 3'd4
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic incomplete;
        logic buffer_end;
    } out_item_t;

    typedef struct packed {
        logic inc;
        logic dec;
    } ctr_cmd_t;

    typedef struct packed {
        ctr_cmd_t brace;
        ctr_cmd_t paren;
        ctr_cmd_t bracket;
    } bump_cmd_t;

endpackage

[hw/rtl/bbl_lex_fsm.sv]
// Lexical mode state machine with escape, pending-slash and pending-star flags.
module bbl_lex_fsm
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         text_byte,
    input  logic               last_byte,
    output bbl_pkg::lex_mode_t mode_next,
    output bbl_pkg::bump_cmd_t cmd
);
    import bbl_pkg::*;

    lex_mode_t mode_reg;
    logic      escape_reg;
    logic      slash_reg;
    logic      star_reg;
    logic      escape_next;
    logic      slash_next;
    logic      star_next;
    logic      code_bytes;

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        escape_next = escape_reg;
        slash_next  = slash_reg;
        star_next   = star_reg;
        unique case (mode_reg)
            MODE_LINE:
            begin
                if (text_byte == CH_NEWLINE)
                begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && text_byte == CH_SLASH)
                begin
                    mode_next = MODE_CODE;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (text_byte == CH_STAR);
                end
            end
            MODE_SQUOTE, MODE_DQUOTE:
            begin
                if (escape_reg)
                begin
                    escape_next = 1'b0;
                end
                else if (text_byte == CH_BSLASH)
                begin
                    escape_next = 1'b1;
                end
                else if ((mode_reg == MODE_SQUOTE && text_byte == CH_SQUOTE) ||
                         (mode_reg == MODE_DQUOTE && text_byte == CH_DQUOTE))
                begin
                    mode_next = MODE_CODE;
                end
            end
            default:
            begin
                mode_next = MODE_CODE;
                if (slash_reg && text_byte == CH_SLASH)
                begin
                    mode_next  = MODE_LINE;
                    slash_next = 1'b0;
                end
                else if (slash_reg && text_byte == CH_STAR)
                begin
                    mode_next  = MODE_BLOCK;
                    slash_next = 1'b0;
                    star_next  = 1'b0;
                end
                else
                begin
                    slash_next = (text_byte == CH_SLASH);
                    if (text_byte == CH_SQUOTE)
                    begin
                        mode_next   = MODE_SQUOTE;
                        escape_next = 1'b0;
                    end
                    else if (text_byte == CH_DQUOTE)
                    begin
                        mode_next   = MODE_DQUOTE;
                        escape_next = 1'b0;
                    end
                end
            end
        endcase
    end

    // outputs: counter bumps only for ordinary code bytes
    always_comb
    begin
        code_bytes = (mode_reg != MODE_LINE) && (mode_reg != MODE_BLOCK) &&
                     (mode_reg != MODE_SQUOTE) && (mode_reg != MODE_DQUOTE) &&
                     !(slash_reg && (text_byte == CH_SLASH || text_byte == CH_STAR));
        cmd.brace.inc   = code_bytes && (text_byte == CH_LBRACE);
        cmd.brace.dec   = code_bytes && (text_byte == CH_RBRACE);
        cmd.paren.inc   = code_bytes && (text_byte == CH_LPAREN);
        cmd.paren.dec   = code_bytes && (text_byte == CH_RPAREN);
        cmd.bracket.inc = code_bytes && (text_byte == CH_LBRACKET);
        cmd.bracket.dec = code_bytes && (text_byte == CH_RBRACKET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CODE;
            escape_reg <= 1'b0;
            slash_reg  <= 1'b0;
            star_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                mode_reg   <= MODE_CODE;
                escape_reg <= 1'b0;
                slash_reg  <= 1'b0;
                star_reg   <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                escape_reg <= escape_next;
                slash_reg  <= slash_next;
                star_reg   <= star_next;
            end
        end
    end

endmodule

[hw/rtl/bbl_sat_ctr.sv]
// Saturating signed depth counter.
module bbl_sat_ctr
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  bbl_pkg::ctr_cmd_t cmd,
    output logic              positive
);
    import bbl_pkg::*;

    logic signed [DEPTH_BITS-1:0] depth_reg;
    logic signed [DEPTH_BITS-1:0] depth_next;

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.inc && depth_reg != DEPTH_MAX)
        begin
            depth_next = depth_reg + DEPTH_ONE;
        end
        else if (cmd.dec && depth_reg != DEPTH_MIN)
        begin
            depth_next = depth_reg - DEPTH_ONE;
        end
        positive = !depth_next[DEPTH_BITS-1] && (depth_next != DEPTH_ZERO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_ZERO;
        end
        else if (step)
        begin
            depth_reg <= clear ? DEPTH_ZERO : depth_next;
        end
    end

endmodule

[hw/rtl/bracket_balance_lexer_top.sv]
// An accepted text item passes the input register and the result register before its verdict item.
// One byte per cycle when not stalled; the lexer state and depth counters update together.
// The verdict register holds a stalled item while the input register can still take one.
// Reset (rst_n low, asynchronous): code mode, all flags and counters zero, no items held.
// A byte marked last_byte returns all lexer state to its reset values after its verdict.
module bracket_balance_lexer_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  bbl_pkg::in_item_t   text_item,
    output logic                verdict_valid,
    input  logic                verdict_stall,
    output bbl_pkg::out_item_t  verdict
);
    import bbl_pkg::*;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      step;
    lex_mode_t mode_next;
    bump_cmd_t cmd;
    logic      brace_pos;
    logic      paren_pos;
    logic      bracket_pos;
    out_item_t result;

    assign step       = s1_valid_reg && (!out_valid_reg || !verdict_stall);
    assign text_stall = s1_valid_reg && !step;

    bbl_lex_fsm u_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (s1_item_reg.text_byte),
        .last_byte (s1_item_reg.last_byte),
        .mode_next (mode_next),
        .cmd       (cmd)
    );

    bbl_sat_ctr u_brace
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .clear    (s1_item_reg.last_byte),
        .cmd      (cmd.brace),
        .positive (brace_pos)
    );

    bbl_sat_ctr u_paren
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .clear    (s1_item_reg.last_byte),
        .cmd      (cmd.paren),
        .positive (paren_pos)
    );

    bbl_sat_ctr u_bracket
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .clear    (s1_item_reg.last_byte),
        .cmd      (cmd.bracket),
        .positive (bracket_pos)
    );

    always_comb
    begin
        result.incomplete = (mode_next == MODE_BLOCK) || (mode_next == MODE_SQUOTE) ||
                            (mode_next == MODE_DQUOTE) || brace_pos || paren_pos ||
                            bracket_pos;
        result.buffer_end = s1_item_reg.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            s1_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
        begin
            s1_item_reg <= text_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !verdict_stall)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_item_reg;

`include "bracket_balance_lexer_top_assert.svh"

    `BBL_ASSERT_NOW(a_stall_only_when_full, text_stall, s1_valid_reg)
    `BBL_ASSERT_NEXT(a_step_fills_result, step, out_valid_reg)
    `BBL_ASSERT_NEXT(a_held_item_kept, s1_valid_reg && !step, s1_valid_reg)

endmodule

[dv/testbench.sv]
// Self-checking testbench for the bracket balance lexer: directed, random, counter and stall tests.
`timescale 1ns / 100ps

module testbench;
    import bbl_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int STUCK_LIMIT  = 2000;
    localparam int MAX_PRINTS   = 40;
    localparam int DEPTH_RUN    = 16;

    typedef logic signed [DEPTH_BITS-1:0] depth_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       text_valid;
    logic       text_stall;
    in_item_t   text_item;
    logic       verdict_valid;
    logic       verdict_stall;
    out_item_t  verdict;

    // lexer state as the checker sees it
    lex_mode_t  mode_q = MODE_CODE;
    logic       esc_q = 1'b0;
    logic       slash_q = 1'b0;
    logic       star_q = 1'b0;
    depth_t     brace_lvl = '0;
    depth_t     paren_lvl = '0;
    depth_t     bracket_lvl = '0;

    out_item_t  verdict_q[$];
    logic [7:0] text_q[$];
    out_item_t  want;

    bit         tx_gaps = 1'b0;
    bit         rx_gaps = 1'b0;
    logic       hold_req;
    int         hold_left = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         verdicts_seen = 0;
    int         buffers_closed = 0;

    bracket_balance_lexer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_item     (text_item),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic depth_t sat_step(input depth_t v, input bit up);
        if (up)
            return (v == DEPTH_MAX) ? v : v + DEPTH_ONE;
        return (v == DEPTH_MIN) ? v : v - DEPTH_ONE;
    endfunction

    function automatic void clear_lexer();
        mode_q      = MODE_CODE;
        esc_q       = 1'b0;
        slash_q     = 1'b0;
        star_q      = 1'b0;
        brace_lvl   = '0;
        paren_lvl   = '0;
        bracket_lvl = '0;
    endfunction

    function automatic out_item_t predict_verdict(input in_item_t it);
        logic [7:0] c;
        out_item_t  r;
        c = it.text_byte;
        case (mode_q)
            MODE_LINE:
            begin
                if (c == CH_NEWLINE)
                    mode_q = MODE_CODE;
            end
            MODE_BLOCK:
            begin
                if (star_q && c == CH_SLASH)
                begin
                    mode_q = MODE_CODE;
                    star_q = 1'b0;
                end
                else
                    star_q = (c == CH_STAR);
            end
            MODE_SQUOTE, MODE_DQUOTE:
            begin
                if (esc_q)
                    esc_q = 1'b0;
                else if (c == CH_BSLASH)
                    esc_q = 1'b1;
                else if (c == ((mode_q == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE))
                    mode_q = MODE_CODE;
            end
            default:
            begin
                mode_q = MODE_CODE;
                if (slash_q && (c == CH_SLASH || c == CH_STAR))
                begin
                    slash_q = 1'b0;
                    if (c == CH_SLASH)
                        mode_q = MODE_LINE;
                    else
                    begin
                        mode_q = MODE_BLOCK;
                        star_q = 1'b0;
                    end
                end
                else
                begin
                    slash_q = (c == CH_SLASH);
                    case (c)
                        CH_SQUOTE:
                        begin
                            mode_q = MODE_SQUOTE;
                            esc_q  = 1'b0;
                        end
                        CH_DQUOTE:
                        begin
                            mode_q = MODE_DQUOTE;
                            esc_q  = 1'b0;
                        end
                        CH_LBRACE:   brace_lvl   = sat_step(brace_lvl, 1'b1);
                        CH_RBRACE:   brace_lvl   = sat_step(brace_lvl, 1'b0);
                        CH_LPAREN:   paren_lvl   = sat_step(paren_lvl, 1'b1);
                        CH_RPAREN:   paren_lvl   = sat_step(paren_lvl, 1'b0);
                        CH_LBRACKET: bracket_lvl = sat_step(bracket_lvl, 1'b1);
                        CH_RBRACKET: bracket_lvl = sat_step(bracket_lvl, 1'b0);
                        default: ;
                    endcase
                end
            end
        endcase
        r.incomplete = (mode_q == MODE_BLOCK) || (mode_q == MODE_SQUOTE) ||
                       (mode_q == MODE_DQUOTE) || (brace_lvl > DEPTH_ZERO) ||
                       (paren_lvl > DEPTH_ZERO) || (bracket_lvl > DEPTH_ZERO);
        r.buffer_end = it.last_byte;
        if (it.last_byte)
            clear_lexer();
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // verdict side: checking, stall generation and the stuck-cycle count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (verdict_valid && !verdict_stall)
            begin
                verdicts_seen++;
                if (verdict.buffer_end)
                    buffers_closed++;
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("verdict %0d arrived with none expected",
                                              verdicts_seen));
                else
                begin
                    want = verdict_q.pop_front();
                    if (verdict.incomplete !== want.incomplete)
                        report_mismatch($sformatf("verdict %0d incomplete %b, expected %b",
                                                  verdicts_seen, verdict.incomplete,
                                                  want.incomplete));
                    if (verdict.buffer_end !== want.buffer_end)
                        report_mismatch($sformatf("verdict %0d buffer_end %b, expected %b",
                                                  verdicts_seen, verdict.buffer_end,
                                                  want.buffer_end));
                end
            end

            if ((text_valid && !text_stall) || (verdict_valid && !verdict_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (hold_req)
            begin
                hold_req <= 1'b0;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                verdict_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                verdict_stall <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(1, 11) - 1;
                verdict_stall <= 1'b1;
            end
            else
                verdict_stall <= 1'b0;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("Watchdog: no item moved for %0d cycles", STUCK_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps && $urandom_range(0, 7) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= in_item_t'{text_byte: b, last_byte: last};
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        verdict_q.push_back(predict_verdict(in_item_t'{text_byte: b, last_byte: last}));
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit close_buf);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close_buf && (i == s.len() - 1));
    endtask

    task automatic wait_for_verdicts();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    function automatic logic [7:0] bracket_char(input bit opener);
        case ($urandom_range(0, 2))
            0:       return opener ? CH_LBRACE : CH_RBRACE;
            1:       return opener ? CH_LPAREN : CH_RPAREN;
            default: return opener ? CH_LBRACKET : CH_RBRACKET;
        endcase
    endfunction

    function automatic logic [7:0] filler_char();
        case ($urandom_range(0, 11))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_BSLASH;
            3:       return CH_NEWLINE;
            4:       return CH_DQUOTE;
            5:       return CH_SQUOTE;
            6:       return 8'($urandom_range(0, 255));
            7:       return bracket_char(1'($urandom_range(0, 1)));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void append_fragment();
        int n;
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0:
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_SLASH);
                repeat (n) text_q.push_back(filler_char());
                text_q.push_back(CH_NEWLINE);
            end
            1:
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_STAR);
                repeat (n) text_q.push_back(filler_char());
                text_q.push_back(CH_STAR);
                text_q.push_back(CH_SLASH);
            end
            2:
            begin
                text_q.push_back(CH_DQUOTE);
                repeat (n) text_q.push_back(filler_char());
                text_q.push_back(CH_DQUOTE);
            end
            3:
            begin
                text_q.push_back(CH_SQUOTE);
                repeat (n) text_q.push_back(filler_char());
                text_q.push_back(CH_SQUOTE);
            end
            4: repeat (n + 1) text_q.push_back(bracket_char(1'b1));
            5: repeat (n + 1) text_q.push_back(bracket_char(1'b0));
            6: repeat (n + 1) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            7:
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(filler_char());
            end
            8: text_q.push_back(8'($urandom_range(0, 255)));
            default: text_q.push_back(CH_STAR);
        endcase
    endfunction

    task automatic send_code_buffer();
        text_q.delete();
        repeat ($urandom_range(1, 6)) append_fragment();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic test_directed_cases();
        // zero byte, top byte, surplus closer
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("}", 1'b1);
        // slash before code, line comment hiding a bracket
        send_text("/(//[\n)", 1'b1);
        // opening star cannot close; star left pending at buffer end
        send_text("/*/*", 1'b1);
        // escaped quotes in both literal kinds, then trailing slash
        send_text("\"\\\"'\"", 1'b0);
        send_text("'\\''", 1'b0);
        send_text("{/", 1'b1);
        wait_for_verdicts();
    endtask

    task automatic test_code_buffers();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 550)
            send_code_buffer();
        wait_for_verdicts();
    endtask

    task automatic test_verdict_hold();
        bit keep;
        keep = tx_gaps;
        wait_for_verdicts();
        tx_gaps = 1'b0;
        hold_req <= 1'b1;
        for (int i = 0; i < 24; i++)
            send_byte(filler_char(), i == 23);
        tx_gaps = keep;
        wait_for_verdicts();
    endtask

    task automatic test_raw_bytes();
        for (int i = 0; i < 300; i++)
            send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0) || i == 299);
        wait_for_verdicts();
    endtask

    task automatic test_counter_swing();
        bit keep_tx;
        bit keep_rx;
        keep_tx = tx_gaps;
        keep_rx = rx_gaps;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        // up, down through zero into negative depth, back up to zero
        repeat (DEPTH_RUN) send_text("{([", 1'b0);
        repeat (2 * DEPTH_RUN) send_text("}])", 1'b0);
        repeat (DEPTH_RUN) send_text("{([", 1'b0);
        send_text("}])", 1'b1);
        wait_for_verdicts();
        tx_gaps = keep_tx;
        rx_gaps = keep_rx;
    endtask

    task automatic test_quiet_tail();
        int start;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        start = bytes_sent;
        while (bytes_sent - start < 200)
            send_code_buffer();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        text_valid    = 1'b0;
        text_item     = '0;
        verdict_stall = 1'b0;
        hold_req      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        test_directed_cases();
        test_code_buffers();
        test_verdict_hold();
        test_raw_bytes();
        test_counter_swing();
        test_quiet_tail();

        wait_for_verdicts();
        repeat (6) @(posedge clk);
        $display("Checked %0d verdicts for %0d text items over %0d buffers,",
                 verdicts_seen, bytes_sent, buffers_closed);
        $display("with comments, literals, negative counters and verdict hold-off.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
